>>> rtl/ucdl_pkg.sv
package ucdl_pkg;

	localparam int FRAME_MAX_DEF = 64;
	localparam int MIN_FRAME = 6;
	localparam logic [7:0] HDR_OK = 8'h2C;
	localparam logic [7:0] TERM_BYTE = 8'h5B;

	localparam int WEIGHT_W = 17;
	localparam logic [WEIGHT_W-1:0] Q16_ONE = 17'd65536;
	localparam logic [WEIGHT_W-1:0] SMOOTH_RESET = 17'd60948;

	localparam int X_W = 16;
	localparam int Y_W = 8;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_SMOOTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_SMOOTH = 1'b1;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_HDR  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// One frame event handed from the parser to the filter.
	typedef struct packed {
		status_t        status;
		logic [X_W-1:0] x_raw;
		logic [Y_W-1:0] y_raw;
	} frame_evt_t;

endpackage

>>> rtl/ucdl_front.sv
module ucdl_front #(
	parameter int FRAME_MAX = ucdl_pkg::FRAME_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  logic [7:0]          byte_data,
	output logic                byte_ready,
	input  logic                evt_full,
	output logic                evt_push,
	output ucdl_pkg::frame_evt_t evt_data
);
	import ucdl_pkg::*;

	localparam int CW = $clog2(FRAME_MAX);

	logic [CW-1:0] count_q;
	logic [7:0]    header_q;
	logic [7:0]    x_high_q;
	logic [7:0]    x_low_q;
	logic [7:0]    y_raw_q;

	logic [CW:0] count_next;
	logic        accept;
	logic        is_term;
	logic        is_ovf;

	assign byte_ready = !evt_full;
	assign accept     = byte_valid && byte_ready;
	assign count_next = {1'b0, count_q} + (CW+1)'(1);
	assign is_term    = (count_next >= (CW+1)'(MIN_FRAME)) && (byte_data == TERM_BYTE);
	assign is_ovf     = !is_term && (count_next == (CW+1)'(FRAME_MAX));
	assign evt_push   = accept && (is_term || is_ovf);

	// The terminator sits at position five or later, so every kept byte is
	// already registered when the frame closes.
	always_comb begin
		evt_data.x_raw = {x_high_q, x_low_q};
		evt_data.y_raw = y_raw_q;
		if (!is_term) begin
			evt_data.status = ST_OVERFLOW;
		end else if (header_q == HDR_OK) begin
			evt_data.status = ST_OK;
		end else begin
			evt_data.status = ST_BAD_HDR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (is_term || is_ovf) begin
				count_q <= '0;
			end else begin
				count_q <= count_next[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (count_q == CW'(0)) header_q <= byte_data;
			if (count_q == CW'(2)) x_high_q <= byte_data;
			if (count_q == CW'(3)) x_low_q  <= byte_data;
			if (count_q == CW'(4)) y_raw_q  <= byte_data;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} < (CW+1)'(FRAME_MAX))
		else $error("frame count reached the frame limit");

	a_clear_after_evt: assert property (@(posedge clk) disable iff (!arst_n)
		evt_push |=> count_q == '0)
		else $error("frame count not cleared after a frame event");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		evt_full |-> !evt_push)
		else $error("event pushed into a full queue");

endmodule

>>> rtl/ucdl_queue.sv
module ucdl_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ucdl_pkg::frame_evt_t push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output ucdl_pkg::frame_evt_t head_data
);
	import ucdl_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	frame_evt_t              mem_q [QUEUE_DEPTH];
	logic [PW-1:0]           wr_ptr_q;
	logic [PW-1:0]           rd_ptr_q;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] count_q;

	assign full       = (count_q == $bits(count_q)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + $bits(count_q)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - $bits(count_q)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= $bits(count_q)'(QUEUE_DEPTH))
		else $error("queue holds more entries than its depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + $bits(count_q)'(1))
		else $error("queue count did not follow a push");

endmodule

>>> rtl/ucdl_filter.sv
module ucdl_filter (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_wen,
	input  logic [ucdl_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [ucdl_pkg::WEIGHT_W-1:0]            cfg_wdata,
	input  logic                                     evt_valid,
	input  ucdl_pkg::frame_evt_t                     evt_data,
	output logic                                     evt_pop,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output ucdl_pkg::status_t                        out_status,
	output logic [ucdl_pkg::X_W-1:0]                 out_x,
	output logic [ucdl_pkg::Y_W-1:0]                 out_y
);
	import ucdl_pkg::*;

	logic [WEIGHT_W-1:0] x_weight_q;
	logic [WEIGHT_W-1:0] y_weight_q;
	logic [X_W-1:0]      x_prev_q;
	logic [Y_W-1:0]      y_prev_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [X_W-1:0]      out_x_q;
	logic [Y_W-1:0]      out_y_q;

	logic [WEIGHT_W-1:0] ax;
	logic [WEIGHT_W-1:0] bx;
	logic [WEIGHT_W-1:0] ay;
	logic [WEIGHT_W-1:0] by;
	logic [32:0]         acc_x;
	logic [24:0]         acc_y;
	logic [X_W-1:0]      x_new;
	logic [Y_W-1:0]      y_new;
	logic                fire;
	logic                is_ok;

	assign fire    = evt_valid && (!out_valid_q || out_ready);
	assign evt_pop = fire;
	assign is_ok   = (evt_data.status == ST_OK);

	// Weights above one are clamped to one.
	assign ax = (x_weight_q > Q16_ONE) ? Q16_ONE : x_weight_q;
	assign ay = (y_weight_q > Q16_ONE) ? Q16_ONE : y_weight_q;
	assign bx = Q16_ONE - ax;
	assign by = Q16_ONE - ay;

	assign acc_x = 33'(ax) * 33'(evt_data.x_raw) + 33'(bx) * 33'(x_prev_q);
	assign acc_y = 25'(ay) * 25'(evt_data.y_raw) + 25'(by) * 25'(y_prev_q);
	assign x_new = acc_x[16 +: X_W];
	assign y_new = acc_y[16 +: Y_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_weight_q <= SMOOTH_RESET;
			y_weight_q <= SMOOTH_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_X_SMOOTH: x_weight_q <= cfg_wdata;
				CFG_Y_SMOOTH: y_weight_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_prev_q    <= '0;
			y_prev_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire && is_ok) begin
				x_prev_q <= x_new;
				y_prev_q <= y_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_status_q <= evt_data.status;
			out_x_q      <= is_ok ? x_new : x_prev_q;
			out_y_q      <= is_ok ? y_new : y_prev_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;

	a_hold_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !is_ok) |=> $stable(x_prev_q) && $stable(y_prev_q))
		else $error("filter state changed on a dropped frame");

	a_fire_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("result register not loaded after an event");

	a_out_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (out_x_q == x_prev_q) && (out_y_q == y_prev_q))
		else $error("reported values differ from the filter state");

endmodule

>>> rtl/uart_coord_deframer_lowpass.sv
// Serial coordinate deframer with first-order low-pass smoothing.
// Throughput: one received byte per cycle; the input stalls only while two
// results wait behind a stalled output. The beat that closes a frame pushes
// its event into the event queue; the filter loads its result register from
// the queue head once the output is free. Reset clears the frame count,
// the filter state and the queue and loads both weights with 60948 (0.93 in Q16).
module uart_coord_deframer_lowpass #(
	parameter int FRAME_MAX = ucdl_pkg::FRAME_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [ucdl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ucdl_pkg::WEIGHT_W-1:0]  cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [23:0]                    m_tdata,   // [15:0] x_filtered, [23:16] y_filtered
	output logic [1:0]                     m_tuser    // [1:0] status
);
	import ucdl_pkg::*;

	frame_evt_t     push_data;
	frame_evt_t     head_data;
	logic           push;
	logic           pop;
	logic           full;
	logic           head_valid;
	status_t        out_status;
	logic [X_W-1:0] out_x;
	logic [Y_W-1:0] out_y;

	ucdl_front #(
		.FRAME_MAX(FRAME_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(s_tvalid),
		.byte_data (s_tdata),
		.byte_ready(s_tready),
		.evt_full  (full),
		.evt_push  (push),
		.evt_data  (push_data)
	);

	ucdl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	ucdl_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.evt_valid (head_valid),
		.evt_data  (head_data),
		.evt_pop   (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_status(out_status),
		.out_x     (out_x),
		.out_y     (out_y)
	);

	assign m_tdata = {out_y, out_x};
	assign m_tuser = out_status;

endmodule
